// ----- design/gss_pkg.sv -----
package gss_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int SIZE_W      = 12;
  localparam int SIZE_MIN    = 3;
  localparam int SIZE_RESET  = 2048;
  localparam int CMP_W       = 18;
  localparam int VAL_W       = 32;
  localparam int IN_FIELDS   = 7;
  localparam int IN_TDATA_W  = VAL_W * IN_FIELDS;
  localparam int PROD_W      = 2 * VAL_W - 16;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SIZE_W-1:0]        size_t;
  typedef logic [CMP_W-1:0]         cmp_t;

  function automatic cmp_t last_index(input size_t size, input cmp_t limit);
    cmp_t s;
    s = CMP_W'(size);
    if (s < CMP_W'(SIZE_MIN)) begin
      return CMP_W'(SIZE_MIN - 1);
    end else if (s > limit) begin
      return limit - 1'b1;
    end
    return s - 1'b1;
  endfunction

  // Q16.16 product, floor to Q16.16 by dropping the low 16 bits
  function automatic prod_t mul_q16(input val_t a, input val_t b);
    logic signed [2*VAL_W-1:0] p;
    p = (2*VAL_W)'(a) * (2*VAL_W)'(b);
    return p[2*VAL_W-1:16];
  endfunction

  function automatic val_t sat32(input sum_t v);
    if (v > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < sum_t'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// ----- design/gss_ram.sv -----
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/gauss_seidel_stencil_sweep_core.sv -----
// Gauss-Seidel sweep core for a 2D five-point stencil.
// Input stream (s_*): one grid cell per beat in raster order, row 0 first,
// column 0 first. Each beat carries the held value, the old east and south
// neighbours and the four coupling coefficients of that cell.
// Output stream (m_*): one beat per input beat, same order: the updated
// value, a boundary flag (tuser) and the last cell of the grid (tlast).
// Config channel (cfg_*): index 0 writes grid_width, index 1 grid_height;
// always ready. Write only while no cell is in flight.
// Each cell passes the input stage, the feedback stage and the output
// register. Throughput: one cell per cycle unless the receiver stalls.
// The west-neighbour feedback (two multipliers, three-term add, saturation)
// is combinational; the north value is a row buffer read one stage ahead.
// Reset clears the cell position to row 0, column 0, the west value to
// zero and both sizes to 2048. The row buffer is not cleared: every read for
// an interior cell hits an entry written one row earlier in the same sweep.
// When the receiver stalls, the output beat holds and the two internal
// stages fill; s_tready drops once all three are occupied.
module gauss_seidel_stencil_sweep_core
  import gss_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // held_value, east_old, south_old, coef_north, coef_south, coef_east,
  // coef_west (32 bits each, from the lowest bit up)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // new_value
  output logic [VAL_W-1:0]       m_tdata,
  // is_boundary
  output logic                   m_tuser,
  output logic                   m_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  size_t grid_width;
  size_t grid_height;
  cmp_t  col_last;
  cmp_t  row_last;

  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic          at_last_col;
  logic          at_last_row;
  logic          s_beat;

  // input stage
  logic          a_valid;
  logic [XW-1:0] a_col;
  logic          a_edge;
  logic          a_last;
  val_t          a_held, a_east, a_south, a_cn, a_cs, a_ce, a_cw;
  pair_t         a_pair;

  // feedback stage
  logic          b_valid;
  logic [XW-1:0] b_col;
  logic          b_edge;
  logic          b_last;
  val_t          b_held, b_cn, b_cw;
  pair_t         b_pair;
  val_t          north;
  val_t          west_result;
  sum_t          b_sum;
  val_t          b_result;

  logic out_free, b_adv, b_free, a_adv, a_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(SIZE_RESET);
      grid_height <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign col_last = last_index(grid_width, CMP_W'(MAX_WIDTH));
  assign row_last = last_index(grid_height, CMP_W'(MAX_HEIGHT));

  assign at_last_col = CMP_W'(column_count) >= col_last;
  assign at_last_row = CMP_W'(row_count) >= row_last;

  assign out_free = !m_tvalid || m_tready;
  assign b_adv    = b_valid && out_free;
  assign b_free   = !b_valid || b_adv;
  assign a_adv    = a_valid && b_free;
  assign a_free   = !a_valid || a_adv;
  assign s_tready = a_free;
  assign s_beat   = s_tvalid && s_tready;

  // cell position of the next beat
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (s_beat) begin
      if (at_last_col) begin
        column_count <= '0;
        row_count    <= at_last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      a_col   <= column_count;
      a_edge  <= (column_count == '0) || (row_count == '0) || at_last_col || at_last_row;
      a_last  <= at_last_col && at_last_row;
      a_held  <= s_tdata[0*VAL_W +: VAL_W];
      a_east  <= s_tdata[1*VAL_W +: VAL_W];
      a_south <= s_tdata[2*VAL_W +: VAL_W];
      a_cn    <= s_tdata[3*VAL_W +: VAL_W];
      a_cs    <= s_tdata[4*VAL_W +: VAL_W];
      a_ce    <= s_tdata[5*VAL_W +: VAL_W];
      a_cw    <= s_tdata[6*VAL_W +: VAL_W];
    end
  end

  // east and south terms do not depend on earlier results
  assign a_pair = PAIR_W'(mul_q16(a_east, a_ce)) + PAIR_W'(mul_q16(a_south, a_cs));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_col  <= a_col;
      b_edge <= a_edge;
      b_last <= a_last;
      b_held <= a_held;
      b_cn   <= a_cn;
      b_cw   <= a_cw;
      b_pair <= a_pair;
    end
  end

  gss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (b_adv),
    .wr_addr (b_col),
    .wr_data (b_result),
    .rd_en   (a_adv),
    .rd_addr (a_col),
    .rd_data (north)
  );

  assign b_sum = SUM_W'(mul_q16(west_result, b_cw)) + SUM_W'(mul_q16(north, b_cn))
               + SUM_W'(b_pair);
  assign b_result = b_edge ? b_held : sat32(b_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      west_result <= '0;
    end else if (b_adv) begin
      west_result <= b_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      m_tdata <= b_result;
      m_tuser <= b_edge;
      m_tlast <= b_last;
    end
  end

endmodule

// ----- test/gauss_seidel_stencil_sweep_core_tb.sv -----
module gauss_seidel_stencil_sweep_core_tb;
  import gss_pkg::*;

  localparam val_t Q_MAX = 32'h7FFF_FFFF;
  localparam val_t Q_MIN = 32'h8000_0000;
  localparam val_t Q_ONE = 32'h0001_0000;
  localparam val_t Q_QTR = 32'h0000_4000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    val_t value;
    bit   boundary;
    bit   last;
  } cell_result_t;

  class stencil_scoreboard;
    size_t        width_reg;
    size_t        height_reg;
    val_t         west_val;
    val_t         north_row [MAX_WIDTH_DEF];
    int unsigned  col;
    int unsigned  row;
    cell_result_t pending_q [$];
    int           errors;
    int           cells;
    int           sweeps;

    function new();
      width_reg = SIZE_RESET;
      height_reg = SIZE_RESET;
      west_val = '0;
      col = 0;
      row = 0;
      errors = 0;
      cells = 0;
      sweeps = 0;
      foreach (north_row[i]) north_row[i] = '0;
    endfunction

    function void set_size(logic [CFG_INDEX_W-1:0] idx, size_t data);
      if (idx == REG_GRID_WIDTH) begin
        width_reg = data;
      end else begin
        height_reg = data;
      end
    endfunction

    function int unsigned clamp_size(size_t raw, int unsigned hi);
      if (raw < SIZE_MIN) return SIZE_MIN;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function longint floor_mul(val_t a, val_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
    endfunction

    function bit at_origin();
      return (col == 0) && (row == 0);
    endfunction

    function void note_cell(val_t held, val_t east, val_t south, val_t cn, val_t cs,
                            val_t ce, val_t cw);
      int unsigned  w;
      int unsigned  h;
      int unsigned  slot;
      bit           last_c;
      bit           last_r;
      bit           on_edge;
      longint       acc;
      cell_result_t r;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      h = clamp_size(height_reg, MAX_HEIGHT_DEF);
      last_c = col >= w - 1;
      last_r = row >= h - 1;
      on_edge = (col == 0) || (row == 0) || last_c || last_r;
      slot = (col < MAX_WIDTH_DEF) ? col : MAX_WIDTH_DEF - 1;
      if (on_edge) begin
        r.value = held;
      end else begin
        acc = floor_mul(west_val, cw) + floor_mul(north_row[slot], cn) +
              floor_mul(east, ce) + floor_mul(south, cs);
        if (acc > SAT_HI) begin
          r.value = Q_MAX;
        end else if (acc < SAT_LO) begin
          r.value = Q_MIN;
        end else begin
          r.value = val_t'(acc);
        end
      end
      r.boundary = on_edge;
      r.last = last_c && last_r;
      west_val = r.value;
      north_row[slot] = r.value;
      if (last_c) begin
        col = 0;
        row = last_r ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      pending_q.push_back(r);
      cells++;
    endfunction

    function void check_result(val_t value, bit boundary, bit last);
      cell_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, nothing pending: actual value %h boundary %b last %b",
                 $time, value, boundary, last);
        return;
      end
      want = pending_q.pop_front();
      if (value !== want.value) begin
        errors++;
        $display("%0t: new_value mismatch: expected %h actual %h", $time, want.value, value);
      end
      if (boundary !== want.boundary) begin
        errors++;
        $display("%0t: is_boundary mismatch: expected %b actual %b", $time, want.boundary,
                 boundary);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_sweep mismatch: expected %b actual %b", $time, want.last, last);
      end
      if (want.last) sweeps++;
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [VAL_W-1:0]       m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]      cfg_data;

  stencil_scoreboard sb;
  int send_idle;
  int recv_idle;
  int cycle_count;
  int size_writes;

  gauss_seidel_stencil_sweep_core dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic val_t pick_value();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return '1;
      4, 5, 6: return val_t'(int'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000);
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic val_t pick_coef();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return val_t'(int'(Q_QTR) + int'($urandom_range(0, 32'h1FFF)) - 32'h1000);
      6: return Q_MIN;
      7: return Q_MAX;
      8: return '0;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic size_t pick_size(int hi);
    if ($urandom_range(9) == 0) return size_t'($urandom_range(0, 2));
    return size_t'($urandom_range(3, hi));
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, size_t data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(idx, data);
    size_writes++;
    @(negedge clk);
  endtask

  task automatic send_cell(val_t held, val_t east, val_t south, val_t cn, val_t cs, val_t ce,
                           val_t cw);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {cw, ce, cs, cn, south, east, held};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cell(held, east, south, cn, cs, ce, cw);
    @(negedge clk);
  endtask

  task automatic edge_cell(val_t held);
    send_cell(held, val_t'($urandom), val_t'($urandom), val_t'($urandom), val_t'($urandom),
              val_t'($urandom), val_t'($urandom));
  endtask

  task automatic send_random_cell();
    send_cell(pick_value(), pick_value(), pick_value(), pick_coef(), pick_coef(), pick_coef(),
              pick_coef());
  endtask

  task automatic finish_sweep();
    do begin
      send_random_cell();
    end while (!sb.at_origin());
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // start an oversized grid, stop partway, then shrink it so the position wraps
  task automatic oversize_then_shrink(bit by_height, size_t big);
    int w;
    if (!by_height) begin
      write_reg(REG_GRID_WIDTH, big);
      write_reg(REG_GRID_HEIGHT, size_t'($urandom_range(3, 6)));
      repeat ($urandom_range(8, 40)) send_random_cell();
      drain_results();
      write_reg(REG_GRID_WIDTH, size_t'($urandom_range(0, 6)));
    end else begin
      w = $urandom_range(3, 6);
      write_reg(REG_GRID_WIDTH, size_t'(w));
      write_reg(REG_GRID_HEIGHT, big);
      repeat (w * $urandom_range(3, 8) + $urandom_range(0, w - 1)) send_random_cell();
      drain_results();
      write_reg(REG_GRID_HEIGHT, size_t'($urandom_range(0, 3)));
    end
    finish_sweep();
    drain_results();
  endtask

  initial begin
    int mode;
    int target;
    int reps;
    sb = new();
    rst = 1'b1;
    s_tdata = '0;
    s_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    send_idle = 25;
    recv_idle = 79;
    size_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 3x3 grid from undersized writes
    write_reg(REG_GRID_WIDTH, size_t'(0));
    write_reg(REG_GRID_HEIGHT, size_t'(2));
    edge_cell(Q_MIN);
    edge_cell(Q_MAX);
    edge_cell('0);
    send_cell('1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_cell(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    edge_cell(Q_ONE);
    edge_cell(32'h0000_0001);
    edge_cell(32'h0000_FFFF);
    edge_cell(32'hFFFF_0000);
    drain_results();

    // 4x4 grid: saturation both ways, floor of a negative product, plain update
    write_reg(REG_GRID_WIDTH, size_t'(4));
    write_reg(REG_GRID_HEIGHT, size_t'(4));
    edge_cell(32'h5555_5555);
    edge_cell(32'hAAAA_AAAA);
    edge_cell(Q_ONE);
    edge_cell(-Q_ONE);
    edge_cell(Q_MIN);
    send_cell(Q_MAX, Q_MIN, Q_MAX, '0, Q_MIN, Q_MAX, Q_MAX);
    send_cell('0, '1, '0, '0, '0, 32'h0000_0001, '0);
    edge_cell(Q_MAX);
    edge_cell(Q_ONE);
    send_cell('0, Q_MIN, '0, '0, '0, Q_MIN, '0);
    send_cell('0, Q_ONE << 1, -Q_ONE, Q_QTR, Q_QTR, Q_QTR, Q_QTR);
    edge_cell('0);
    edge_cell(32'h1234_5678);
    edge_cell(32'hFEDC_BA98);
    edge_cell('0);
    edge_cell(Q_MAX);
    drain_results();

    for (mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 25 : (mode == 1) ? 79 : 0;
      recv_idle = (mode == 0) ? 79 : (mode == 1) ? 25 : 0;
      target = sb.cells + 270;
      if (mode == 2) begin
        oversize_then_shrink(1'b0, size_t'(MAX_WIDTH_DEF));
        oversize_then_shrink(1'b1, size_t'(MAX_HEIGHT_DEF));
      end else begin
        oversize_then_shrink(mode == 1, size_t'(4095));
      end
      while (sb.cells < target) begin
        write_reg(REG_GRID_WIDTH, pick_size(12));
        write_reg(REG_GRID_HEIGHT, pick_size(10));
        reps = $urandom_range(1, 2);
        repeat (reps) finish_sweep();
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("covered %0d cells in %0d complete sweeps with %0d size writes", sb.cells,
             sb.sweeps, size_writes);
    $display("grids from 3x3 to 2048-cell rows, mid-sweep shrinks, three stall mixes");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- gauss_seidel_stencil_sweep_core.f -----
design/gss_pkg.sv
design/gss_ram.sv
design/gauss_seidel_stencil_sweep_core.sv
test/gauss_seidel_stencil_sweep_core_tb.sv
